[sv/dbns_pkg.sv]
// Shared types and constants for the directory block name search.
// Used by the channel interface, the top level and the bench.
`default_nettype none

package dbns_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int POS_W      = 17;
    localparam int OFF_W      = 9;
    localparam int RECLEN_W   = 16;
    localparam int INODE_W    = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LENGTH = 2'd1;

    localparam logic [POS_W-1:0] BLOCK_SIZE_RESET    = 17'd1024;
    localparam logic [7:0]       TARGET_LENGTH_RESET = 8'd1;

    // Byte offsets inside one directory entry header.
    localparam logic [OFF_W-1:0] OFF_INODE_END = 9'd4;
    localparam logic [OFF_W-1:0] OFF_RECLEN_LO = 9'd4;
    localparam logic [OFF_W-1:0] OFF_RECLEN_HI = 9'd6 - 9'd1;
    localparam logic [OFF_W-1:0] OFF_NAME_LEN  = 9'd6;
    localparam logic [OFF_W-1:0] OFF_TYPE      = 9'd7;
    localparam logic [OFF_W-1:0] OFF_NAME      = 9'd8;

    typedef enum logic {
        CMD_NAME  = 1'b0,
        CMD_BLOCK = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_FOUND      = 2'd0,
        ST_END_MARK   = 2'd1,
        ST_EXHAUSTED  = 2'd2,
        ST_BAD_RECLEN = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] data_byte;
        logic [7:0] name_index;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [INODE_W-1:0]   inode_number;
    } t_out_item;

endpackage

`default_nettype wire

[sv/dbns_chan_if.sv]
// Valid/ready channel carrying one request payload of a package type.
// Depends on dbns_pkg for the default payload type.
`default_nettype none

interface dbns_chan_if #(
    parameter type t_payload = dbns_pkg::t_in_item
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[sv/dbns_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module dbns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 255,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/directory_block_name_search.sv]
// Top level of the directory block name search.
// Depends on dbns_pkg, dbns_chan_if and dbns_ram.
//
// The block takes one request per clock cycle unless the input is stalled,
// either a target name byte or a directory block byte, and gives at most one
// result per block: the inode of the entry whose name matches, or the reason
// the search stopped. A block byte waits in an input register, where the name
// store is read, and its result is then registered in the output register.
// The name store read for a byte is issued when the byte is accepted, using
// the entry offset that the previous byte leaves. A held result stalls the
// input only when the next byte also has a result.
`default_nettype none

module directory_block_name_search #(
    parameter int MAX_NAME_BYTES = 255
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [dbns_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [dbns_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    dbns_chan_if.sink                             i_in,
    dbns_chan_if.source                           o_out
);

    localparam int NAME_AW = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
    localparam logic [dbns_pkg::OFF_W-1:0] NAME_LIM = dbns_pkg::OFF_W'(MAX_NAME_BYTES);

    // Configuration.
    logic [dbns_pkg::POS_W-1:0] r_block_size;
    logic [7:0]                 r_target_length;

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_byte;

    // Per-block scan state.
    logic [dbns_pkg::POS_W-1:0]    r_pos,      n_pos;
    logic [dbns_pkg::OFF_W-1:0]    r_off,      n_off;
    logic [dbns_pkg::RECLEN_W-1:0] r_skip,     n_skip;
    logic [dbns_pkg::RECLEN_W-1:0] r_rec_len,  n_rec_len;
    logic [7:0]                    r_name_len, n_name_len;
    logic [dbns_pkg::INODE_W-1:0]  r_inode,    n_inode;
    logic                          r_matching, n_matching;
    logic                          r_decided,  n_decided;

    // Output register.
    logic                r_out_valid;
    dbns_pkg::t_out_item r_out, n_out;

    logic                      emit;
    logic                      advance;
    logic                      stage_go;
    logic                      out_free;
    logic                      in_accept;
    logic                      blk_accept;
    logic                      name_we;
    logic [7:0]                name_rdata;
    logic [dbns_pkg::OFF_W-1:0] name_pos;
    logic [dbns_pkg::OFF_W-1:0] rd_pos;
    logic                      name_ok;
    logic                      name_last;
    logic                      in_name;
    logic                      block_end;

    assign in_accept  = i_in.valid && i_in.ready;
    assign blk_accept = in_accept && (i_in.payload.cmd == dbns_pkg::CMD_BLOCK);
    assign name_we    = in_accept && (i_in.payload.cmd == dbns_pkg::CMD_NAME)
                        && ({1'b0, i_in.payload.name_index} < NAME_LIM);

    assign out_free   = !r_out_valid || o_out.ready;
    assign stage_go   = r_in_valid && (!emit || out_free);
    assign i_in.ready = !r_in_valid || stage_go;

    assign rd_pos = n_off - dbns_pkg::OFF_NAME;

    dbns_ram #(
        .WIDTH (8),
        .DEPTH (MAX_NAME_BYTES)
    ) u_name_store (
        .i_clk   (i_clk),
        .i_we    (name_we),
        .i_waddr (i_in.payload.name_index[NAME_AW-1:0]),
        .i_wdata (i_in.payload.data_byte),
        .i_re    (blk_accept),
        .i_raddr (rd_pos[NAME_AW-1:0]),
        .o_rdata (name_rdata)
    );

    assign name_pos  = r_off - dbns_pkg::OFF_NAME;
    assign name_ok   = (name_pos < NAME_LIM) && (name_rdata == r_byte);
    assign in_name   = r_off < (dbns_pkg::OFF_NAME + {1'b0, r_name_len});
    assign name_last = r_off == (dbns_pkg::OFF_TYPE + {1'b0, r_name_len});
    assign block_end = ({1'b0, r_pos} + 18'd1) >= {1'b0, r_block_size};

    always_comb begin
        n_pos      = r_pos;
        n_off      = r_off;
        n_skip     = r_skip;
        n_rec_len  = r_rec_len;
        n_name_len = r_name_len;
        n_inode    = r_inode;
        n_matching = r_matching;
        n_decided  = r_decided;
        n_out      = r_out;
        emit       = 1'b0;
        advance    = 1'b0;

        if (r_in_valid) begin
            if (!r_decided && (r_skip == '0)) begin
                n_off = r_off + 9'd1;
                if (r_off < dbns_pkg::OFF_INODE_END) begin
                    case (r_off[1:0])
                        2'd0:    n_inode[7:0]   = r_byte;
                        2'd1:    n_inode[15:8]  = r_byte;
                        2'd2:    n_inode[23:16] = r_byte;
                        2'd3:    n_inode[31:24] = r_byte;
                        default: n_inode        = r_inode;
                    endcase
                end else if (r_off == dbns_pkg::OFF_RECLEN_LO) begin
                    n_rec_len[7:0] = r_byte;
                end else if (r_off == dbns_pkg::OFF_RECLEN_HI) begin
                    n_rec_len[15:8] = r_byte;
                end else if (r_off == dbns_pkg::OFF_NAME_LEN) begin
                    n_name_len = r_byte;
                end else if (r_off == dbns_pkg::OFF_TYPE) begin
                    n_matching = 1'b1;
                    if (r_byte == 8'd0) begin
                        emit             = 1'b1;
                        n_out.status       = dbns_pkg::ST_END_MARK;
                        n_out.inode_number = '0;
                    end else if (r_name_len != r_target_length) begin
                        advance = 1'b1;
                    end else if (r_name_len == 8'd0) begin
                        emit             = 1'b1;
                        n_out.status       = dbns_pkg::ST_FOUND;
                        n_out.inode_number = r_inode;
                    end
                end else if (in_name) begin
                    n_matching = r_matching && name_ok;
                    if (name_last) begin
                        if (n_matching) begin
                            emit             = 1'b1;
                            n_out.status       = dbns_pkg::ST_FOUND;
                            n_out.inode_number = r_inode;
                        end else begin
                            advance = 1'b1;
                        end
                    end
                end

                // The next entry starts record-length bytes after this one.
                if (advance) begin
                    if (r_rec_len <= {7'd0, r_off}) begin
                        emit             = 1'b1;
                        n_out.status       = dbns_pkg::ST_BAD_RECLEN;
                        n_out.inode_number = '0;
                    end else begin
                        n_skip = r_rec_len - {7'd0, r_off} - 16'd1;
                        n_off  = '0;
                    end
                end
            end else if (!r_decided) begin
                n_skip = r_skip - 16'd1;
            end

            if (emit) begin
                n_decided = 1'b1;
            end

            if (block_end) begin
                if (!emit && !r_decided) begin
                    emit             = 1'b1;
                    n_out.status       = dbns_pkg::ST_EXHAUSTED;
                    n_out.inode_number = '0;
                end
                n_pos      = '0;
                n_off      = '0;
                n_skip     = '0;
                n_matching = 1'b1;
                n_decided  = 1'b0;
            end else begin
                n_pos = r_pos + 17'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size    <= dbns_pkg::BLOCK_SIZE_RESET;
            r_target_length <= dbns_pkg::TARGET_LENGTH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dbns_pkg::CFG_BLOCK_SIZE:    r_block_size    <= i_cfg_data;
                dbns_pkg::CFG_TARGET_LENGTH: r_target_length <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= blk_accept;
        end
        if (blk_accept) begin
            r_byte <= i_in.payload.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_off      <= '0;
            r_skip     <= '0;
            r_matching <= 1'b1;
            r_decided  <= 1'b0;
        end else if (stage_go) begin
            r_pos      <= n_pos;
            r_off      <= n_off;
            r_skip     <= n_skip;
            r_matching <= n_matching;
            r_decided  <= n_decided;
        end
        if (stage_go) begin
            r_rec_len  <= n_rec_len;
            r_name_len <= n_name_len;
            r_inode    <= n_inode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_go && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (stage_go && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

`default_nettype wire

[bench/directory_block_name_search_tb.sv]
// Self-checking bench for the directory block name search top level.
// Depends on dbns_pkg, dbns_chan_if and the directory_block_name_search RTL.
// Directed entries, then random directory blocks under varied idling.
`default_nettype none

module directory_block_name_search_tb;

    localparam int          NAME_SLOTS   = 255;
    localparam int unsigned POS_LIMIT    = 32'h1FFFF;
    localparam int unsigned DRAIN_LIMIT  = 20000;
    localparam int unsigned SETTLE_TICKS = 8;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            cfg_we;
    logic [dbns_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dbns_pkg::CFG_DATA_W-1:0] cfg_data;

    dbns_chan_if #(.t_payload(dbns_pkg::t_in_item))  req_if ();
    dbns_chan_if #(.t_payload(dbns_pkg::t_out_item)) res_if ();

    directory_block_name_search #(
        .MAX_NAME_BYTES(NAME_SLOTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (req_if),
        .o_out       (res_if)
    );

    // Stimulus side.
    dbns_pkg::t_in_item stream_bytes [$];
    logic [7:0]         block_bytes [$];
    int unsigned        block_cap;
    logic [7:0]         planned_name [NAME_SLOTS];
    int unsigned        send_gap_pct   = 0;
    int unsigned        recv_stall_pct = 0;
    bit                 req_shown = 1'b0;
    bit                 req_taken = 1'b0;

    // Lookup predictor state.
    logic [7:0]  name_copy [NAME_SLOTS];
    logic [16:0] cfg_block_size = dbns_pkg::BLOCK_SIZE_RESET;
    logic [7:0]  cfg_target_len = dbns_pkg::TARGET_LENGTH_RESET;
    int unsigned scan_pos       = 0;
    int unsigned entry_base     = 0;
    logic [15:0] entry_reclen   = '0;
    logic [7:0]  entry_namelen  = '0;
    logic [31:0] entry_inode    = '0;
    bit          name_ok        = 1'b1;
    bit          block_done     = 1'b0;

    dbns_pkg::t_out_item expected_lookups [$];
    dbns_pkg::t_out_item want_res;
    int unsigned         mismatch_count = 0;

    function automatic void clear_scan();
        scan_pos      = 0;
        entry_base    = 0;
        entry_reclen  = '0;
        entry_namelen = '0;
        entry_inode   = '0;
        name_ok       = 1'b1;
        block_done    = 1'b0;
    endfunction

    function automatic void record_outcome(input dbns_pkg::t_status st,
                                           input logic [31:0] ino);
        dbns_pkg::t_out_item r;
        r.status       = st;
        r.inode_number = ino;
        expected_lookups.push_back(r);
        block_done = 1'b1;
    endfunction

    // A record length that does not reach past the deciding byte cannot advance.
    function automatic void next_entry(input int unsigned off);
        int unsigned nxt;
        if (entry_reclen <= off) begin
            record_outcome(dbns_pkg::ST_BAD_RECLEN, '0);
        end else begin
            nxt        = entry_base + entry_reclen;
            entry_base = (nxt > POS_LIMIT) ? POS_LIMIT : nxt;
        end
    endfunction

    function automatic void predict_lookup(input dbns_pkg::t_in_item it);
        int unsigned pos;
        int unsigned off;
        int unsigned idx;
        if (it.cmd == dbns_pkg::CMD_NAME) begin
            if (it.name_index < NAME_SLOTS) begin
                name_copy[it.name_index] = it.data_byte;
            end
            return;
        end
        pos = scan_pos;
        if (!block_done && pos >= entry_base) begin
            off = pos - entry_base;
            if (off < dbns_pkg::OFF_INODE_END) begin
                entry_inode[8*off +: 8] = it.data_byte;
            end else if (off == dbns_pkg::OFF_RECLEN_LO) begin
                entry_reclen[7:0] = it.data_byte;
            end else if (off == dbns_pkg::OFF_RECLEN_HI) begin
                entry_reclen[15:8] = it.data_byte;
            end else if (off == dbns_pkg::OFF_NAME_LEN) begin
                entry_namelen = it.data_byte;
            end else if (off == dbns_pkg::OFF_TYPE) begin
                name_ok = 1'b1;
                if (it.data_byte == 8'h00) begin
                    record_outcome(dbns_pkg::ST_END_MARK, '0);
                end else if (entry_namelen != cfg_target_len) begin
                    next_entry(off);
                end else if (entry_namelen == 8'h00) begin
                    record_outcome(dbns_pkg::ST_FOUND, entry_inode);
                end
            end else if (off < dbns_pkg::OFF_NAME + entry_namelen) begin
                idx = off - dbns_pkg::OFF_NAME;
                if (idx >= NAME_SLOTS || name_copy[idx] != it.data_byte) begin
                    name_ok = 1'b0;
                end
                if (off == dbns_pkg::OFF_TYPE + entry_namelen) begin
                    if (name_ok) begin
                        record_outcome(dbns_pkg::ST_FOUND, entry_inode);
                    end else begin
                        next_entry(off);
                    end
                end
            end
        end
        if (pos + 1 >= cfg_block_size) begin
            if (!block_done) begin
                record_outcome(dbns_pkg::ST_EXHAUSTED, '0);
            end
            clear_scan();
        end else begin
            scan_pos = pos + 1;
        end
    endfunction

    task automatic queue_name_write(input logic [7:0] idx, input logic [7:0] val);
        dbns_pkg::t_in_item it;
        it.cmd        = dbns_pkg::CMD_NAME;
        it.data_byte  = val;
        it.name_index = idx;
        if (idx < NAME_SLOTS) begin
            planned_name[idx] = val;
        end
        stream_bytes.push_back(it);
    endtask

    task automatic begin_block(input int unsigned cap);
        block_bytes.delete();
        block_cap = cap;
    endtask

    task automatic push_entry(input logic [31:0] inode, input logic [15:0] reclen,
                              input logic [7:0] nlen, input logic [7:0] ftype,
                              input bit spoil);
        int unsigned start;
        int unsigned j;
        start = block_bytes.size();
        for (j = 0; j < 4; j++) begin
            block_bytes.push_back(inode[8*j +: 8]);
        end
        block_bytes.push_back(reclen[7:0]);
        block_bytes.push_back(reclen[15:8]);
        block_bytes.push_back(nlen);
        block_bytes.push_back(ftype);
        for (j = 0; j < nlen; j++) begin
            block_bytes.push_back(planned_name[j]);
        end
        if (spoil && nlen != 0) begin
            j = start + 8 + $urandom_range(0, nlen - 1);
            block_bytes[j] = block_bytes[j] ^ 8'($urandom_range(1, 255));
        end
        while (block_bytes.size() < start + reclen && block_bytes.size() < block_cap) begin
            block_bytes.push_back(8'($urandom));
        end
    endtask

    // Streams exactly count block bytes, padding or cutting the built entries.
    task automatic send_block(input int unsigned count);
        dbns_pkg::t_in_item it;
        int unsigned        k;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(99) < 2) begin
                queue_name_write(8'($urandom), 8'($urandom));
            end
            it.cmd        = dbns_pkg::CMD_BLOCK;
            it.data_byte  = (k < block_bytes.size()) ? block_bytes[k] : 8'($urandom);
            it.name_index = 8'($urandom);
            stream_bytes.push_back(it);
        end
    endtask

    task automatic fill_block(input int unsigned count, input int unsigned tlen);
        int unsigned r;
        int unsigned nl;
        int unsigned pad;
        int unsigned dec;
        begin_block(count);
        while (block_bytes.size() < count) begin
            r   = $urandom_range(99);
            nl  = tlen;
            pad = 4 * $urandom_range(0, 3);
            if (r < 30) begin
                push_entry($urandom, 16'(8 + nl + pad), 8'(nl), 8'($urandom_range(1, 255)), 1'b0);
            end else if (r < 55) begin
                push_entry($urandom, 16'(8 + nl + pad), 8'(nl), 8'($urandom_range(1, 255)), 1'b1);
            end else if (r < 75) begin
                nl = $urandom_range(0, 20);
                if (nl == tlen) begin
                    nl = (tlen + 1) % 256;
                end
                push_entry($urandom, 16'(8 + nl + pad), 8'(nl), 8'($urandom_range(1, 255)), 1'b0);
            end else if (r < 83) begin
                push_entry($urandom, 16'(8 + nl + pad), 8'(nl), 8'h00, 1'b0);
            end else if (r < 90) begin
                if ($urandom_range(1) == 0) begin
                    nl = $urandom_range(0, 20);
                end
                dec = (nl == tlen) ? 7 + nl : 7;
                push_entry($urandom, 16'($urandom_range(0, dec)), 8'(nl),
                           8'($urandom_range(1, 255)), nl == tlen);
            end else if (r < 95) begin
                nl = (tlen + 1) % 256;
                push_entry($urandom, 16'($urandom_range(1024, 65535)), 8'(nl),
                           8'($urandom_range(1, 255)), 1'b0);
            end else begin
                repeat ($urandom_range(1, 12)) block_bytes.push_back(8'($urandom));
            end
        end
        send_block(count);
    endtask

    task automatic write_reg(input logic [dbns_pkg::CFG_IDX_W-1:0] idx,
                             input logic [dbns_pkg::CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == dbns_pkg::CFG_BLOCK_SIZE) begin
            cfg_block_size = val;
        end else if (idx == dbns_pkg::CFG_TARGET_LENGTH) begin
            cfg_target_len = val[7:0];
        end
    endtask

    task automatic wait_idle();
        int unsigned n;
        n = 0;
        while ((stream_bytes.size() != 0 || req_shown || expected_lookups.size() != 0)
               && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("directory_block_name_search verification failed");
        $finish;
    end

    // Request driver: a request stays presented until it is taken.
    always @(negedge i_clk) begin
        if (req_taken) begin
            void'(stream_bytes.pop_front());
            req_taken = 1'b0;
            req_shown = 1'b0;
        end
        if (!req_shown) begin
            if (i_rst_n && stream_bytes.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                req_if.payload <= stream_bytes[0];
                req_if.valid   <= 1'b1;
                req_shown = 1'b1;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                predict_lookup(req_if.payload);
                req_taken = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_lookups.size() == 0) begin
                    $display("%0t: unexpected result, status %0d inode %h", $time,
                             res_if.payload.status, res_if.payload.inode_number);
                    mismatch_count++;
                end else begin
                    want_res = expected_lookups.pop_front();
                    if (res_if.payload.status !== want_res.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want_res.status, res_if.payload.status);
                        mismatch_count++;
                    end
                    if (res_if.payload.inode_number !== want_res.inode_number) begin
                        $display("%0t: inode expected %h actual %h", $time,
                                 want_res.inode_number, res_if.payload.inode_number);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin
        int unsigned ph;
        int unsigned bsize;
        int unsigned tlen;
        int unsigned i;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        res_if.ready   = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        i_rst_n        = 1'b0;
        for (i = 0; i < NAME_SLOTS; i++) begin
            name_copy[i]    = 8'h00;
            planned_name[i] = 8'h00;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every name slot is written before any block byte can read it.
        for (i = 0; i < NAME_SLOTS; i++) begin
            queue_name_write(8'(i), (i == 0) ? 8'hFF : (i == 1) ? 8'h00 : 8'($urandom));
        end
        queue_name_write(8'hFF, 8'hA5);

        // Reset settings: length mismatches, an empty name, then a match.
        begin_block(1024);
        push_entry($urandom, 16'd12, 8'd3, 8'd1, 1'b0);
        push_entry(32'h0, 16'd8, 8'd0, 8'd2, 1'b0);
        push_entry(32'hFFFF_FFFF, 16'd9, 8'd1, 8'hFF, 1'b0);
        send_block(1024);
        wait_idle();

        // Short blocks: a spoiled match, a zero record length, a runaway record.
        write_reg(dbns_pkg::CFG_BLOCK_SIZE, 17'd32);
        begin_block(32);
        push_entry(32'h0, 16'd16, 8'd1, 8'd1, 1'b1);
        push_entry($urandom, 16'd8, 8'd0, 8'h00, 1'b0);
        send_block(32);
        begin_block(32);
        push_entry($urandom, 16'd0, 8'd5, 8'd1, 1'b0);
        send_block(32);
        begin_block(32);
        push_entry($urandom, 16'hFFFF, 8'd2, 8'd1, 1'b0);
        send_block(32);
        wait_idle();

        // A zero block size ends a block at every byte.
        write_reg(dbns_pkg::CFG_BLOCK_SIZE, 17'd0);
        begin_block(3);
        send_block(3);
        wait_idle();

        // Empty target name on one-header blocks.
        write_reg(dbns_pkg::CFG_BLOCK_SIZE, 17'd8);
        write_reg(dbns_pkg::CFG_TARGET_LENGTH, 17'd0);
        begin_block(8);
        push_entry($urandom, 16'd8, 8'd0, 8'd3, 1'b0);
        send_block(8);
        begin_block(8);
        push_entry($urandom, 16'd8, 8'd0, 8'h00, 1'b0);
        send_block(8);
        begin_block(8);
        push_entry($urandom, 16'd20, 8'd4, 8'd1, 1'b0);
        send_block(8);
        begin_block(8);
        push_entry($urandom, 16'd3, 8'd2, 8'd1, 1'b0);
        send_block(8);
        wait_idle();

        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 45; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 45; end
                default: begin send_gap_pct = 7; recv_stall_pct = 7; end
            endcase
            if (ph == 7) begin
                bsize = 272;
                tlen  = 255;
            end else if (ph == 5) begin
                bsize = 32;
                tlen  = 1;
            end else begin
                bsize = $urandom_range(24, 40);
                tlen  = $urandom_range(1, 8);
            end
            write_reg(dbns_pkg::CFG_BLOCK_SIZE, 17'(bsize));
            write_reg(dbns_pkg::CFG_TARGET_LENGTH, 17'(tlen));
            @(posedge i_clk);
            repeat (8) queue_name_write(8'($urandom), 8'($urandom));
            repeat ((ph == 7) ? 1 : 2) fill_block(bsize, tlen);
            wait_idle();
        end

        if (expected_lookups.size() != 0 || stream_bytes.size() != 0) begin
            $display("%0t: %0d results and %0d requests left over", $time,
                     expected_lookups.size(), stream_bytes.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("directory_block_name_search verification clean");
        end else begin
            $display("directory_block_name_search verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
sv/dbns_pkg.sv
sv/dbns_chan_if.sv
sv/dbns_ram.sv
sv/directory_block_name_search.sv
bench/directory_block_name_search_tb.sv
